// ===== hw/rtl/mvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvsm_pkg
// field widths, action and status codes and the saturating add shared by the
// sample mixer modules
// ----------------------------------------------------------------------------
package mvsm_pkg;

  // item field widths
  localparam int ACT_W      = 2;
  localparam int ADDR_W     = 16;
  localparam int LEN_W      = 17;
  localparam int SMP_W      = 16;
  localparam int STAT_W     = 2;
  localparam int SLOT_W     = 5;
  localparam int CNT_OUT_W  = 6;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - SMP_W - STAT_W - SLOT_W - CNT_OUT_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUEUE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_LEN = 2'd2;

  // longest sound in samples
  localparam logic [LEN_W-1:0] MAX_LEN = 17'h1_0000;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  // add two pcm words and clamp to the 16-bit range
  function automatic logic signed [SMP_W-1:0] sat_add(
    input logic signed [SMP_W-1:0] a,
    input logic signed [SMP_W-1:0] b
  );
    logic signed [SMP_W:0] s;
    s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
    if (s[SMP_W] != s[SMP_W-1]) begin
      return s[SMP_W] ? SMP_MIN : SMP_MAX;
    end
    return s[SMP_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/multi_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// saturating pcm playback mixer for NUM_VOICES voices over a shared sample ram
// ----------------------------------------------------------------------------
// usage:
//   in channel: one beat per command, tuser carries the action (load word,
//   queue sound, tick, clear), tdata the address, length and pcm word
//   out channel: exactly one result beat per command beat, in order
//   steps per command, from acceptance until the result can be taken:
//     tick  : each voice slot in turn through the voice table read, the
//             sample ram read and the single saturating adder
//     load  : the address reduction, then the sample ram write
//     queue : the address reduction, then a scan up to the lowest free slot;
//             zero length or full table goes straight to the result
//     clear : straight to the result
//   in_tready is high only while the sequencer is idle; a finished result sits
//   in the output register, so the next beat is taken while it waits
//   if the receiver stalls with a result still held, the next result waits in
//   the sequencer and in_tready stays low until the output register drains
//   reset frees every voice slot; the sample ram and voice table keep their
//   contents and read as undefined until written
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer import mvsm_pkg::*; #(
  parameter int NUM_VOICES       = 32,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // address [15:0], sound_length [32:16], sample_in [48:33], zero pad above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action [1:0]
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mix_out [15:0], status [17:16], slot_taken [22:18], active_voices [28:23]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // sample ram address width, voice index width, voice count width
  localparam int MAW   = (SAMPLE_MEM_DEPTH > 1) ? $clog2(SAMPLE_MEM_DEPTH) : 1;
  localparam int VIW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW    = $clog2(NUM_VOICES + 1);
  // voice table entry: remaining samples above the current read address
  localparam int ENT_W = MAW + LEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REM  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CW-1:0]  NV_C       = CW'(NUM_VOICES);
  localparam logic [MAW-1:0] ADDR_LAST  = MAW'(SAMPLE_MEM_DEPTH - 1);

  // sequencer and item registers
  logic [2:0]               state_r, state_nxt;
  logic [ACT_W-1:0]         act_r, act_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [SMP_W-1:0]         smp_r, smp_nxt;
  logic signed [SMP_W-1:0]  mix_r, mix_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic [VIW-1:0]           slot_r, slot_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [NUM_VOICES-1:0]    active_r, active_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  // tick pipeline: stage 1 has the voice entry, stage 2 has the sample word
  logic                     p1_v_r, p1_v_nxt;
  logic [VIW-1:0]           p1_idx_r, p1_idx_nxt;
  logic                     p2_v_r, p2_v_nxt;
  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  logic                     in_fire;
  logic [ACT_W-1:0]         in_act;
  logic [ADDR_W-1:0]        in_addr;
  logic [LEN_W-1:0]         in_len;
  logic [SMP_W-1:0]         in_smp;

  logic                     rem_start;
  logic                     rem_done;
  logic [MAW-1:0]           rem_val;

  logic                     smem_we;
  logic [SMP_W-1:0]         smem_q;
  logic                     vtab_we;
  logic [VIW-1:0]           vtab_waddr;
  logic [ENT_W-1:0]         vtab_wdata;
  logic [ENT_W-1:0]         vtab_q;

  logic [MAW-1:0]           ent_addr;
  logic [LEN_W-1:0]         ent_left;
  logic                     p1_act;
  logic [VIW-1:0]           cnt_idx;
  logic                     issue;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_act    = in_tuser;
  assign in_addr   = in_tdata[15:0];
  assign in_len    = in_tdata[32:16];
  assign in_smp    = in_tdata[48:33];

  assign cnt_idx   = cnt_r[VIW-1:0];
  assign issue     = (cnt_r != NV_C);
  assign ent_addr  = vtab_q[MAW-1:0];
  assign ent_left  = vtab_q[ENT_W-1:MAW];
  assign p1_act    = active_r[p1_idx_r];

  // address reduction is needed by load and by a queue that can succeed
  assign rem_start = in_fire &&
                     ((in_act == ACT_LOAD) ||
                      ((in_act == ACT_QUEUE) && (in_len != '0) && (count_r != NV_C)));

  assign smem_we   = (state_r == S_REM) && rem_done && (act_r == ACT_LOAD);

  mvsm_rem #(
    .DIVISOR (SAMPLE_MEM_DEPTH)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (in_addr),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // pcm word store, written on load, read once per active voice on tick
  mvsm_ram #(
    .WIDTH (SMP_W),
    .DEPTH (SAMPLE_MEM_DEPTH)
  ) u_smem (
    .clk   (clk),
    .we    (smem_we),
    .waddr (rem_val),
    .wdata (smp_r),
    .raddr (ent_addr),
    .rdata (smem_q)
  );

  // per-voice read address and remaining sample count
  mvsm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_VOICES)
  ) u_vtab (
    .clk   (clk),
    .we    (vtab_we),
    .waddr (vtab_waddr),
    .wdata (vtab_wdata),
    .raddr (cnt_idx),
    .rdata (vtab_q)
  );

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    len_nxt       = len_r;
    smp_nxt       = smp_r;
    mix_nxt       = mix_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    p1_v_nxt      = 1'b0;
    p1_idx_nxt    = p1_idx_r;
    p2_v_nxt      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    vtab_we       = 1'b0;
    vtab_waddr    = p1_idx_r;
    vtab_wdata    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt    = in_act;
          len_nxt    = (in_len > MAX_LEN) ? MAX_LEN : in_len;
          smp_nxt    = in_smp;
          mix_nxt    = '0;
          status_nxt = STAT_OK;
          slot_nxt   = '0;
          cnt_nxt    = '0;
          unique case (in_act)
            ACT_LOAD: begin
              state_nxt = S_REM;
            end
            ACT_QUEUE: begin
              if (in_len == '0) begin
                status_nxt = STAT_BAD_LEN;
                state_nxt  = S_DONE;
              end else if (count_r == NV_C) begin
                status_nxt = STAT_NO_ROOM;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_REM;
              end
            end
            ACT_TICK: begin
              state_nxt = S_TICK;
            end
            ACT_CLEAR: begin
              active_nxt = '0;
              count_nxt  = '0;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_REM: begin
        if (rem_done) begin
          // load writes the ram this cycle; queue goes on to find a slot
          state_nxt = (act_r == ACT_LOAD) ? S_DONE : S_SCAN;
        end
      end

      S_SCAN: begin
        // lowest free slot, one slot per cycle; one is known to be free
        if (!active_r[cnt_idx]) begin
          vtab_we             = 1'b1;
          vtab_waddr          = cnt_idx;
          vtab_wdata          = {len_r, rem_val};
          active_nxt[cnt_idx] = 1'b1;
          count_nxt           = count_r + 1'b1;
          slot_nxt            = cnt_idx;
          state_nxt           = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_TICK: begin
        // stage 0: read the voice entry of the next slot
        if (issue) begin
          cnt_nxt    = cnt_r + 1'b1;
          p1_v_nxt   = 1'b1;
          p1_idx_nxt = cnt_idx;
        end
        // stage 1: entry is out, sample read goes to the ram, entry advances
        if (p1_v_r && p1_act) begin
          p2_v_nxt   = 1'b1;
          vtab_we    = 1'b1;
          vtab_waddr = p1_idx_r;
          vtab_wdata = {ent_left - 1'b1,
                        (ent_addr == ADDR_LAST) ? MAW'(0) : ent_addr + 1'b1};
          if (ent_left == LEN_W'(1)) begin
            active_nxt[p1_idx_r] = 1'b0;
            count_nxt            = count_r - 1'b1;
          end
        end
        // stage 2: sample is out, add it in slot order
        if (p2_v_r) begin
          mix_nxt = sat_add(mix_r, signed'(smem_q));
        end
        if (!issue && !p1_v_r && !p2_v_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {OUT_PAD_W'(0), CNT_OUT_W'(count_r), SLOT_W'(slot_r),
                           status_r, mix_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      active_r    <= '0;
      cnt_r       <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    len_r      <= len_nxt;
    smp_r      <= smp_nxt;
    mix_r      <= mix_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    p1_idx_r   <= p1_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/mvsm_ram.sv =====
// ----------------------------------------------------------------------------
// mvsm_ram
// simple dual-port ram, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module mvsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mvsm_rem.sv =====
// ----------------------------------------------------------------------------
// mvsm_rem
// remainder of a 16-bit address by the constant memory depth, reciprocal
// multiply then one correcting subtract, each step registered in turn
// ----------------------------------------------------------------------------
module mvsm_rem import mvsm_pkg::*; #(
  parameter int DIVISOR = 65536,
  localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  output logic              done,
  output logic [RW-1:0]     remainder
);

  // reciprocal scaled by 2^SH, within [2^ADDR_W, 2^(ADDR_W+1)) for any DIVISOR above one
  localparam int SH = ADDR_W + RW;
  localparam int PW = 2 * ADDR_W + 1;
  localparam int TW = (RW > ADDR_W) ? RW + 1 : ADDR_W + 1;
  localparam logic [ADDR_W:0] RECIP = (ADDR_W + 1)'((64'd1 << SH) / DIVISOR);
  localparam logic [TW-1:0]   DIV_C = TW'(DIVISOR);

  logic              s1_r, s1_nxt;
  logic              done_r, done_nxt;
  logic [ADDR_W-1:0] num_r, num_nxt;
  logic [ADDR_W:0]   quo_r, quo_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [PW-1:0]     prod;
  logic [TW-1:0]     diff;

  // first step: quotient estimate, low by at most one
  assign prod = PW'(dividend) * PW'(RECIP);
  // second step: remainder estimate lies in [0, 2 * DIVISOR)
  assign diff = TW'(num_r) - TW'(quo_r) * DIV_C;

  always_comb begin
    s1_nxt   = start;
    done_nxt = s1_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      num_nxt = dividend;
      quo_nxt = (ADDR_W + 1)'(prod >> SH);
    end
    if (s1_r) begin
      rem_nxt = (diff >= DIV_C) ? RW'(diff - DIV_C) : RW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= s1_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== tb/sv/mvsm_mix_checker.sv =====
// ----------------------------------------------------------------------------
// mvsm_mix_checker
// watches both stream channels of the sample mixer, keeps a shadow of the
// voice table and sample ram, and checks every result beat in order
// ----------------------------------------------------------------------------
module mvsm_mix_checker import mvsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // address [15:0], sound_length [32:16], sample_in [48:33], zero pad above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action [1:0]
  input  logic [ACT_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // mix_out [15:0], status [17:16], slot_taken [22:18], active_voices [28:23]
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    n_errors,
  output int                    n_pending,
  output int                    n_checked,
  output int                    n_clipped,
  output int                    n_no_room,
  output int                    peak_voices
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOICES    = 32;
  localparam int RAM_WORDS = 65536;
  localparam int MAX_LINES = 20;

  typedef struct packed {
    logic signed [SMP_W-1:0] mix;
    logic [STAT_W-1:0]       status;
    logic [SLOT_W-1:0]       slot;
    logic [CNT_OUT_W-1:0]    nvoices;
  } mix_result_t;

  logic              v_on   [VOICES];
  logic [ADDR_W-1:0] v_base [VOICES];
  logic [LEN_W-1:0]  v_len  [VOICES];
  logic [ADDR_W-1:0] v_pos  [VOICES];
  logic [SMP_W-1:0]  pcm_ram [RAM_WORDS];
  mix_result_t       want_q [$];

  initial begin
    n_errors    = 0;
    n_pending   = 0;
    n_checked   = 0;
    n_clipped   = 0;
    n_no_room   = 0;
    peak_voices = 0;
    for (int i = 0; i < RAM_WORDS; i++) pcm_ram[i] = '0;
    for (int v = 0; v < VOICES; v++) begin
      v_on[v]   = 1'b0;
      v_base[v] = '0;
      v_len[v]  = '0;
      v_pos[v]  = '0;
    end
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_LINES) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // apply one command beat to the shadow state and return its result
  function automatic mix_result_t mix_step(
    input logic [ACT_W-1:0]  act,
    input logic [ADDR_W-1:0] addr,
    input logic [LEN_W-1:0]  len,
    input logic [SMP_W-1:0]  smp
  );
    mix_result_t       r;
    int                acc;
    int                cnt;
    int                free_slot;
    bit                clipped;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  nxt;
    logic [ADDR_W-1:0] rd;
    r         = '0;
    acc       = 0;
    cnt       = 0;
    free_slot = -1;
    clipped   = 1'b0;
    eff_len   = (len > MAX_LEN) ? MAX_LEN : len;
    case (act)
      ACT_LOAD: pcm_ram[addr] = smp;
      ACT_QUEUE: begin
        if (len == '0) begin
          r.status = STAT_BAD_LEN;
        end else begin
          for (int v = VOICES - 1; v >= 0; v--) if (!v_on[v]) free_slot = v;
          if (free_slot < 0) begin
            r.status = STAT_NO_ROOM;
            n_no_room++;
          end else begin
            v_on[free_slot]   = 1'b1;
            v_base[free_slot] = addr;
            v_len[free_slot]  = eff_len;
            v_pos[free_slot]  = '0;
            r.slot            = free_slot[SLOT_W-1:0];
          end
        end
      end
      ACT_TICK: begin
        // clamp after every voice, in slot order
        for (int v = 0; v < VOICES; v++) begin
          if (v_on[v]) begin
            rd  = v_base[v] + v_pos[v];
            acc = acc + $signed(pcm_ram[rd]);
            if (acc > 32767) begin
              acc     = 32767;
              clipped = 1'b1;
            end else if (acc < -32768) begin
              acc     = -32768;
              clipped = 1'b1;
            end
            nxt = {1'b0, v_pos[v]} + 1'b1;
            if (nxt >= v_len[v]) begin
              v_on[v] = 1'b0;
              nxt     = '0;
            end
            v_pos[v] = nxt[ADDR_W-1:0];
          end
        end
        r.mix = acc[SMP_W-1:0];
        if (clipped) n_clipped++;
      end
      default: begin
        for (int v = 0; v < VOICES; v++) begin
          v_on[v]  = 1'b0;
          v_pos[v] = '0;
        end
      end
    endcase
    for (int v = 0; v < VOICES; v++) if (v_on[v]) cnt++;
    r.nvoices = cnt[CNT_OUT_W-1:0];
    if (cnt > peak_voices) peak_voices = cnt;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    mix_result_t got;
    mix_result_t want;
    if (!rst_n) begin
      want_q.delete();
      for (int v = 0; v < VOICES; v++) begin
        v_on[v]  = 1'b0;
        v_pos[v] = '0;
      end
    end else begin
      // a result can never belong to the command taken at the same edge
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[17:16], out_tdata[22:18], out_tdata[28:23]};
        if (want_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = want_q.pop_front();
          n_checked++;
          if (got.mix !== want.mix)
            report_mismatch($sformatf("mix_out got %0d want %0d", got.mix, want.mix));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.slot !== want.slot)
            report_mismatch($sformatf("slot_taken got %0d want %0d", got.slot, want.slot));
          if (got.nvoices !== want.nvoices)
            report_mismatch($sformatf("active_voices got %0d want %0d",
                                      got.nvoices, want.nvoices));
        end
      end
      if (in_tvalid && in_tready)
        want_q.push_back(mix_step(in_tuser, in_tdata[15:0], in_tdata[32:16], in_tdata[48:33]));
    end
    n_pending = want_q.size();
  end

endmodule

// ===== tb/sv/tb_multi_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// drives load, queue, tick and clear beats into the sample mixer with random
// gaps and receiver stalls; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import mvsm_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 12;
  // every voice reads inside this window of the sample ram, which is loaded
  // before any sound is queued; it straddles the top of the address space
  localparam logic [ADDR_W-1:0] WIN_BASE = 16'hff80;
  localparam int WIN_SIZE       = 256;
  localparam int RAND_BEATS     = 920;
  localparam int QUIET_TAIL     = 150;
  localparam int HOLD_AT        = 300;
  localparam int DRAIN_AT       = 700;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int NO_GUARD       = 1 << 30;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} traffic_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // address [15:0], sound_length [32:16], sample_in [48:33], zero pad above
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  // action [1:0]
  logic [ACT_W-1:0]      in_tuser  = ACT_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // mix_out [15:0], status [17:16], slot_taken [22:18], active_voices [28:23]
  logic [OUT_DATA_W-1:0] out_tdata;

  int n_errors;
  int n_pending;
  int n_checked;
  int n_clipped;
  int n_no_room;
  int peak_voices;

  // ticks left before a sound longer than its share of the window would read
  // past it; a clear is sent in place of the tick that would cross
  int read_guard  = NO_GUARD;
  int tx_gap_pct  = 0;
  int rx_gap_pct  = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  always #CLK_HALF clk = ~clk;

  multi_voice_sample_mixer #(
    .NUM_VOICES      (32),
    .SAMPLE_MEM_DEPTH(65536)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  mvsm_mix_checker mix_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .n_errors   (n_errors),
    .n_pending  (n_pending),
    .n_checked  (n_checked),
    .n_clipped  (n_clipped),
    .n_no_room  (n_no_room),
    .peak_voices(peak_voices)
  );

  // offer one command beat from a falling edge, hold it until taken, and
  // return on the next falling edge
  task automatic send_beat(
    input logic [ACT_W-1:0]  act,
    input logic [ADDR_W-1:0] addr,
    input logic [LEN_W-1:0]  len,
    input logic [SMP_W-1:0]  smp
  );
    logic [ADDR_W-1:0] off;
    logic [LEN_W-1:0]  eff;
    int                room;
    // random sender gap before some beats
    if (!quiet && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_DATA_W - SMP_W - LEN_W - ADDR_W){1'b0}}, smp, len, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // keep the read guard in step with what the block now plays
    off  = addr - WIN_BASE;
    room = WIN_SIZE - int'(off);
    eff  = (len > MAX_LEN) ? MAX_LEN : len;
    case (act)
      ACT_QUEUE: if (len != '0 && int'(eff) > room && room < read_guard) read_guard = room;
      ACT_TICK:  if (read_guard != NO_GUARD) read_guard--;
      ACT_CLEAR: read_guard = NO_GUARD;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // one random command, weighted by the traffic mode
  task automatic random_beat(input traffic_mode_t mode);
    int                pick;
    int                load_pct;
    int                queue_pct;
    int                tick_pct;
    int                room;
    logic [ADDR_W-1:0] off;
    logic [LEN_W-1:0]  len;
    logic [SMP_W-1:0]  smp;
    case (mode)
      MIX_FILL: begin
        load_pct  = 15;
        queue_pct = 62;
        tick_pct  = 22;
      end
      MIX_DRAIN: begin
        load_pct  = 10;
        queue_pct = 10;
        tick_pct  = 78;
      end
      default: begin
        load_pct  = 20;
        queue_pct = 32;
        tick_pct  = 44;
      end
    endcase
    pick = $urandom_range(99);
    if (pick < load_pct) begin
      smp = SMP_W'($urandom);
      if ($urandom_range(9) == 0) smp = $urandom_range(1) ? SMP_MAX : SMP_MIN;
      // half the loads refresh the play window, half land anywhere
      if ($urandom_range(1))
        send_beat(ACT_LOAD, WIN_BASE + ADDR_W'($urandom_range(WIN_SIZE - 1)), '0, smp);
      else send_beat(ACT_LOAD, ADDR_W'($urandom), '0, smp);
    end else if (pick < load_pct + queue_pct) begin
      off  = ADDR_W'($urandom_range(WIN_SIZE - 1));
      room = WIN_SIZE - int'(off);
      pick = $urandom_range(99);
      if (pick < 8) begin
        // zero length, rejected whatever the address
        send_beat(ACT_QUEUE, ADDR_W'($urandom), '0, SMP_W'($urandom));
      end else begin
        if (pick < 13) len = MAX_LEN;
        else if (pick < 16) len = '1;
        else if (pick < 26) len = LEN_W'($urandom);
        else len = LEN_W'(1 + $urandom_range(((room < 40) ? room : 40) - 1));
        send_beat(ACT_QUEUE, WIN_BASE + off, len, SMP_W'($urandom));
      end
    end else if (pick < load_pct + queue_pct + tick_pct) begin
      if (read_guard == 0)
        send_beat(ACT_CLEAR, ADDR_W'($urandom), LEN_W'($urandom), SMP_W'($urandom));
      else send_beat(ACT_TICK, ADDR_W'($urandom), LEN_W'($urandom), SMP_W'($urandom));
    end else begin
      send_beat(ACT_CLEAR, ADDR_W'($urandom), LEN_W'($urandom), SMP_W'($urandom));
    end
  endtask

  // result side: random stall bursts, one long hold-off, none in the tail
  initial begin : result_sink
    int gap_left;
    bit hold_done;
    gap_left  = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // long stall while the sender keeps offering, so the block backs up
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < rx_gap_pct) begin
        gap_left = $urandom_range(11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    traffic_mode_t mode;
    mode = MIX_BALANCED;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // load the whole play window first so no voice ever reads an unloaded word
    tx_gap_pct = 10;
    rx_gap_pct = 10;
    for (int i = 0; i < WIN_SIZE; i++)
      send_beat(ACT_LOAD, WIN_BASE + ADDR_W'(i), '0, SMP_W'($urandom));

    // directed: idle tick and clear, zero length, extremes and the wrap
    send_beat(ACT_TICK, 16'h0000, '0, '0);
    send_beat(ACT_CLEAR, 16'hffff, '1, '1);
    send_beat(ACT_QUEUE, 16'hffff, '0, '1);
    send_beat(ACT_LOAD, 16'hfffe, '0, SMP_MAX);
    send_beat(ACT_LOAD, 16'hffff, '0, SMP_MAX);
    send_beat(ACT_LOAD, 16'h0000, '0, SMP_MIN);
    send_beat(ACT_LOAD, 16'h0001, '0, SMP_MIN);
    send_beat(ACT_LOAD, 16'h0002, '0, 16'h0001);
    // two voices at full scale clip high, a third pulls toward the floor;
    // the first two read across the top of the address space
    send_beat(ACT_QUEUE, 16'hfffe, 17'd5, '0);
    send_beat(ACT_QUEUE, 16'hfffe, 17'd5, '0);
    send_beat(ACT_QUEUE, 16'h0000, 17'd3, '0);
    send_beat(ACT_TICK, '0, '0, '0);
    send_beat(ACT_TICK, '0, '0, '0);
    send_beat(ACT_TICK, '0, '0, '0);
    // overlong length saturates, the longest length plays as queued
    send_beat(ACT_QUEUE, WIN_BASE, '1, '0);
    send_beat(ACT_QUEUE, 16'hfff0, MAX_LEN, '0);
    send_beat(ACT_QUEUE, 16'h0070, 17'd1, '0);
    send_beat(ACT_TICK, '0, '0, '0);
    send_beat(ACT_TICK, '0, '0, '0);
    send_beat(ACT_LOAD, 16'h8000, '0, SMP_W'($urandom));
    send_beat(ACT_CLEAR, '0, '0, '0);
    send_beat(ACT_TICK, '0, '0, '0);

    // random part in blocks of 100 beats, each with its own mix and gap rates
    for (int i = 0; i < RAND_BEATS; i++) begin
      if (i % 100 == 0) begin
        // some blocks are forced to pile up voices until the table is full
        if (i / 100 == 1 || i / 100 == 5) mode = MIX_FILL;
        else mode = traffic_mode_t'($urandom_range(2));
        tx_gap_pct = 15 * $urandom_range(2);
        rx_gap_pct = 15 * $urandom_range(2);
      end
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        // sender pause until every result is back
        in_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        @(negedge clk);
      end
      quiet = (i >= RAND_BEATS - QUIET_TAIL);
      random_beat(mode);
    end

    in_tvalid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("mixer run: %0d results checked, %0d ticks clipped, %0d queues hit a full table",
             n_checked, n_clipped, n_no_room);
    $display("voices peaked at %0d; sounds crossed the ram top, zero and overlong lengths queued",
             peak_voices);
    if (n_errors == 0 && n_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mvsm_pkg.sv
hw/rtl/mvsm_ram.sv
hw/rtl/mvsm_rem.sv
hw/rtl/multi_voice_sample_mixer.sv
tb/sv/mvsm_mix_checker.sv
tb/sv/tb_multi_voice_sample_mixer.sv
